FILE: rtl/bds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and codes of the beacon report store: command and status
// codes, the captured input item and the result item.
// ----------------------------------------------------------------------------
package bds_pkg;

	localparam logic [1:0] CMD_REPORT = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_RSVD   = 2'd3;

	localparam logic [2:0] STATUS_TAKEN    = 3'd0;
	localparam logic [2:0] STATUS_STORED   = 3'd1;
	localparam logic [2:0] STATUS_DUP      = 3'd2;
	localparam logic [2:0] STATUS_FULL     = 3'd3;
	localparam logic [2:0] STATUS_TOO_LONG = 3'd4;
	localparam logic [2:0] STATUS_MISMATCH = 3'd5;
	localparam logic [2:0] STATUS_CLEARED  = 3'd6;
	localparam logic [2:0] STATUS_READ     = 3'd7;

	localparam logic [31:0] ADDR_PATTERN_RST = 32'h484F574C;
	localparam logic [5:0]  POS_LIMIT        = 6'd63;
	localparam logic [5:0]  ID_LO_POS        = 6'd2;
	localparam logic [5:0]  ID_HI_POS        = 6'd3;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [31:0]       peer_address_high;
		logic [7:0]        data_byte;
		logic              last_byte;
		logic signed [7:0] rssi;
		logic [3:0]        read_entry;
		logic [4:0]        read_offset;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] read_byte;
		logic [4:0] entry_count;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/beacon_dedup_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// beacon_dedup_store
// Collects advertising report bytes into fixed slots and drops reports whose
// id is already stored; clear and byte read commands on the same channel.
// ----------------------------------------------------------------------------
// One item is worked at a time by a small sequencer around a single-port slot
// memory; a read in range waits for its registered read data. The last byte
// of a report adds an id scan over the stored slots through the one memory
// port: low id byte, high id byte and compare for each stored entry until a
// match, then the rssi write. After reset and on each clear command the memory
// is swept to zero, one byte a cycle, 2**(clog2(SLOT_COUNT)+clog2(SLOT_BYTES))
// addresses (512 at the default size); in_stall stays high meanwhile, while
// configuration writes are taken as always. A finished result sits in an
// output register so the next item can be accepted while it waits.
// ----------------------------------------------------------------------------
module beacon_dedup_store #(
	parameter int SLOT_COUNT = 16,
	parameter int SLOT_BYTES = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        cmd,
	input  wire logic [31:0]       peer_address_high,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	input  wire logic signed [7:0] rssi,
	input  wire logic [3:0]        read_entry,
	input  wire logic [4:0]        read_offset,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [2:0]        status,
	output logic      [7:0]        read_byte,
	output logic      [4:0]        entry_count
);

	localparam int ROW_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int COL_W  = $clog2(SLOT_BYTES);
	localparam int ADDR_W = ROW_W + COL_W;

	logic [31:0]      pattern_q;
	logic             out_valid_q;
	bds_pkg::result_t out_q;

	bds_pkg::item_t   item;
	logic             item_take;
	logic             item_ready;
	bds_pkg::result_t res;
	logic             res_valid;
	logic             res_ready;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	assign item = '{
		cmd:               cmd,
		peer_address_high: peer_address_high,
		data_byte:         data_byte,
		last_byte:         last_byte,
		rssi:              rssi,
		read_entry:        read_entry,
		read_offset:       read_offset
	};

	assign in_stall  = !item_ready;
	assign item_take = in_valid && item_ready;
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= bds_pkg::ADDR_PATTERN_RST;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				pattern_q <= cfg_wdata;
			end
			if (res_valid && res_ready) begin
				out_q       <= res;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign read_byte   = out_q.read_byte;
	assign entry_count = out_q.entry_count;

	bds_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_BYTES (SLOT_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_take  (item_take),
		.item_ready (item_ready),
		.pattern    (pattern_q),
		.res        (res),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.ram_we     (ram_we),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata)
	);

	bds_slot_ram #(
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("new item taken while previous item in work");

endmodule
`default_nettype wire

FILE: rtl/bds_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_slot_ram
// Single-port byte memory holding the report slots, registered read data.
// ----------------------------------------------------------------------------
module bds_slot_ram #(
	parameter int ADDR_W = 9
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [7:0]        wdata,
	output logic      [7:0]        rdata
);

	logic [7:0] mem_q [2**ADDR_W];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/bds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_ctrl
// Sequencer of the report store: byte ingest, commit checks, id scan over
// the stored slots through the one memory port, reads and clearing sweep.
// ----------------------------------------------------------------------------
module bds_ctrl #(
	parameter int SLOT_COUNT = 16,
	parameter int SLOT_BYTES = 32,
	localparam int ROW_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
	localparam int COL_W  = $clog2(SLOT_BYTES),
	localparam int ADDR_W = ROW_W + COL_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bds_pkg::item_t    item,
	input  wire logic              item_take,
	output logic                   item_ready,
	input  wire logic [31:0]       pattern,
	output bds_pkg::result_t       res,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic                   ram_we,
	output logic      [ADDR_W-1:0] ram_addr,
	output logic      [7:0]        ram_wdata,
	input  wire logic [7:0]        ram_rdata
);

	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_BYTE,
		S_READ,
		S_READ_WAIT,
		S_SCAN_LO,
		S_SCAN_HI,
		S_SCAN_CHK,
		S_RSSI,
		S_DONE
	} state_t;

	state_t           state_q;
	bds_pkg::item_t   item_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic             clr_result_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_q;
	logic [5:0]       pos_q;
	logic [7:0]       len_q;
	logic [15:0]      id_q;
	logic [7:0]       lo_q;
	logic [2:0]       status_q;
	logic [7:0]       rbyte_q;

	logic        pos_zero;
	logic [7:0]  eff_len;
	logic [15:0] id_new;
	logic        not_full;
	logic [8:0]  pos_w;
	logic [8:0]  len_w;
	logic        byte_wr;
	logic        too_long;
	logic        addr_ok;
	logic [8:0]  rd_row_w;
	logic [8:0]  rd_col_w;
	logic        rd_in_range;
	logic [8:0]  rssi_col_w;
	logic [8:0]  cnt_w;
	logic        scan_last;
	logic        id_match;

	always_comb begin
		pos_zero = (pos_q == 6'd0);
		eff_len  = pos_zero ? item_q.data_byte : len_q;
		id_new   = id_q;
		if (pos_q == bds_pkg::ID_LO_POS) begin
			id_new[7:0] = item_q.data_byte;
		end
		if (pos_q == bds_pkg::ID_HI_POS) begin
			id_new[15:8] = item_q.data_byte;
		end
		not_full    = (cnt_q < CNT_W'(SLOT_COUNT));
		pos_w       = 9'(pos_q);
		len_w       = 9'(eff_len);
		byte_wr     = not_full && (pos_w <= len_w) && (pos_w < 9'(SLOT_BYTES));
		too_long    = (10'(eff_len) + 10'd2) > 10'(SLOT_BYTES);
		addr_ok     = (item_q.peer_address_high == pattern);
		rd_row_w    = 9'(item_q.read_entry);
		rd_col_w    = 9'(item_q.read_offset);
		rd_in_range = (rd_row_w < 9'(SLOT_COUNT)) && (rd_col_w < 9'(SLOT_BYTES));
		rssi_col_w  = 9'(len_q) + 9'd1;
		cnt_w       = 9'(cnt_q);
		scan_last   = ((scan_q + CNT_W'(1)) == cnt_q);
		id_match    = ({ram_rdata, lo_q} == id_q);
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = 8'd0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_addr_q;
			end
			S_BYTE: begin
				ram_we    = addr_ok && byte_wr;
				ram_addr  = {cnt_w[ROW_W-1:0], pos_w[COL_W-1:0]};
				ram_wdata = item_q.data_byte;
			end
			S_READ: begin
				ram_addr = {rd_row_w[ROW_W-1:0], rd_col_w[COL_W-1:0]};
			end
			S_SCAN_LO: begin
				ram_addr = {scan_q[ROW_W-1:0], COL_W'(bds_pkg::ID_LO_POS)};
			end
			S_SCAN_HI: begin
				ram_addr = {scan_q[ROW_W-1:0], COL_W'(bds_pkg::ID_HI_POS)};
			end
			S_RSSI: begin
				ram_we    = 1'b1;
				ram_addr  = {cnt_w[ROW_W-1:0], rssi_col_w[COL_W-1:0]};
				ram_wdata = $unsigned(item_q.rssi);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			item_q       <= '0;
			clr_addr_q   <= '0;
			clr_result_q <= 1'b0;
			cnt_q        <= '0;
			scan_q       <= '0;
			pos_q        <= 6'd0;
			len_q        <= 8'd0;
			id_q         <= 16'd0;
			lo_q         <= 8'd0;
			status_q     <= bds_pkg::STATUS_TAKEN;
			rbyte_q      <= 8'd0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == '1) begin
						state_q      <= clr_result_q ? S_DONE : S_IDLE;
						clr_result_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (item_take) begin
						item_q  <= item;
						rbyte_q <= 8'd0;
						unique case (item.cmd) inside
							bds_pkg::CMD_REPORT: begin
								state_q <= S_BYTE;
							end
							bds_pkg::CMD_CLEAR: begin
								cnt_q        <= '0;
								pos_q        <= 6'd0;
								len_q        <= 8'd0;
								id_q         <= 16'd0;
								clr_result_q <= 1'b1;
								status_q     <= bds_pkg::STATUS_CLEARED;
								state_q      <= S_CLEAR;
							end
							bds_pkg::CMD_READ, bds_pkg::CMD_RSVD: begin
								state_q <= S_READ;
							end
						endcase
					end
				end
				S_BYTE: begin
					state_q <= S_DONE;
					if (!addr_ok) begin
						status_q <= bds_pkg::STATUS_MISMATCH;
					end else if (item_q.last_byte) begin
						pos_q <= 6'd0;
						if (too_long) begin
							status_q <= bds_pkg::STATUS_TOO_LONG;
							len_q    <= 8'd0;
							id_q     <= 16'd0;
						end else if (!not_full) begin
							status_q <= bds_pkg::STATUS_FULL;
							len_q    <= 8'd0;
							id_q     <= 16'd0;
						end else begin
							len_q  <= eff_len;
							id_q   <= id_new;
							scan_q <= '0;
							state_q <= (cnt_q == '0) ? S_RSSI : S_SCAN_LO;
						end
					end else begin
						len_q    <= eff_len;
						id_q     <= id_new;
						status_q <= bds_pkg::STATUS_TAKEN;
						if (pos_q < bds_pkg::POS_LIMIT) begin
							pos_q <= pos_q + 6'd1;
						end
					end
				end
				S_READ: begin
					status_q <= bds_pkg::STATUS_READ;
					state_q  <= rd_in_range ? S_READ_WAIT : S_DONE;
				end
				S_READ_WAIT: begin
					rbyte_q <= ram_rdata;
					state_q <= S_DONE;
				end
				S_SCAN_LO: begin
					state_q <= S_SCAN_HI;
				end
				S_SCAN_HI: begin
					lo_q    <= ram_rdata;
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (id_match) begin
						status_q <= bds_pkg::STATUS_DUP;
						len_q    <= 8'd0;
						id_q     <= 16'd0;
						state_q  <= S_DONE;
					end else if (scan_last) begin
						state_q <= S_RSSI;
					end else begin
						scan_q  <= scan_q + CNT_W'(1);
						state_q <= S_SCAN_LO;
					end
				end
				S_RSSI: begin
					cnt_q    <= cnt_q + CNT_W'(1);
					status_q <= bds_pkg::STATUS_STORED;
					len_q    <= 8'd0;
					id_q     <= 16'd0;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res        = '{status: status_q, read_byte: rbyte_q, entry_count: cnt_w[4:0]};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SLOT_COUNT))
		else $error("stored count beyond slot count");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_LO || state_q == S_SCAN_HI || state_q == S_SCAN_CHK) |-> !ram_we)
		else $error("memory write during id scan");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_LO || state_q == S_SCAN_HI || state_q == S_SCAN_CHK)
		|-> (scan_q < cnt_q))
		else $error("id scan past stored entries");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && status_q == bds_pkg::STATUS_CLEARED) |-> (cnt_q == '0))
		else $error("clear result with entries left");

endmodule
`default_nettype wire

FILE: tb/sv/beacon_dedup_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_dedup_store_tb
// Self-checking bench for the beacon report store. A driver offers report
// bytes, clears and reads from a queue of pending items. An in-bench model of
// the slot store predicts status, read byte and entry count for each item
// taken in. A monitor checks every result against the oldest prediction. The
// run steps through several address patterns and idle/stall mixes, and holds
// the output off once for a long stretch.
// ----------------------------------------------------------------------------
module beacon_dedup_store_tb;

	localparam int SLOT_COUNT     = 16;
	localparam int SLOT_BYTES     = 32;
	localparam int PHASE_ITEMS    = 500;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 5000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic [31:0]    cfg_wdata = '0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	bds_pkg::item_t in_item = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	logic [2:0]     status;
	logic [7:0]     read_byte;
	logic [4:0]     entry_count;

	bds_pkg::item_t   byte_cmd_q[$];
	bds_pkg::result_t expected_status_q[$];

	// model of the store
	logic [7:0]  slot_mem [0:SLOT_COUNT*SLOT_BYTES-1] = '{default: 8'h00};
	logic [31:0] addr_pat = bds_pkg::ADDR_PATTERN_RST;
	int          stored_n = 0;
	logic [5:0]  rep_pos = '0;
	logic [7:0]  rep_len = '0;
	logic [15:0] rep_id = '0;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int noise_pct = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;
	int gen_count = 0;
	int items_in = 0;
	int results_seen = 0;
	int errors = 0;
	int idle_cycles = 0;
	int status_cnt [0:7] = '{default: 0};

	beacon_dedup_store #(
		.SLOT_COUNT(SLOT_COUNT),
		.SLOT_BYTES(SLOT_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(in_item.cmd),
		.peer_address_high(in_item.peer_address_high),
		.data_byte(in_item.data_byte),
		.last_byte(in_item.last_byte),
		.rssi(in_item.rssi),
		.read_entry(in_item.read_entry),
		.read_offset(in_item.read_offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_byte(read_byte),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic bds_pkg::result_t dedup_predict(bds_pkg::item_t it);
		bds_pkg::result_t r;
		int pos_now;
		int len;
		int base;
		int k;
		r = '0;
		if (it.cmd == bds_pkg::CMD_CLEAR) begin
			for (k = 0; k < SLOT_COUNT * SLOT_BYTES; k++) slot_mem[k] = 8'h00;
			stored_n = 0;
			rep_pos = '0;
			rep_len = '0;
			rep_id = '0;
			r.status = bds_pkg::STATUS_CLEARED;
		end else if (it.cmd == bds_pkg::CMD_READ || it.cmd == bds_pkg::CMD_RSVD) begin
			if (int'(it.read_entry) < SLOT_COUNT && int'(it.read_offset) < SLOT_BYTES)
				r.read_byte = slot_mem[int'(it.read_entry) * SLOT_BYTES + int'(it.read_offset)];
			r.status = bds_pkg::STATUS_READ;
		end else if (it.peer_address_high != addr_pat) begin
			r.status = bds_pkg::STATUS_MISMATCH;
		end else begin
			pos_now = int'(rep_pos);
			len = (pos_now == 0) ? int'(it.data_byte) : int'(rep_len);
			if (pos_now == 0) rep_len = it.data_byte;
			if (pos_now == int'(bds_pkg::ID_LO_POS)) rep_id[7:0] = it.data_byte;
			if (pos_now == int'(bds_pkg::ID_HI_POS)) rep_id[15:8] = it.data_byte;
			if (stored_n < SLOT_COUNT && pos_now <= len && pos_now < SLOT_BYTES)
				slot_mem[stored_n * SLOT_BYTES + pos_now] = it.data_byte;
			if (it.last_byte) begin
				r.status = bds_pkg::STATUS_STORED;
				if (len + 2 > SLOT_BYTES) begin
					r.status = bds_pkg::STATUS_TOO_LONG;
				end else if (stored_n >= SLOT_COUNT) begin
					r.status = bds_pkg::STATUS_FULL;
				end else begin
					for (k = 0; k < stored_n; k++) begin
						base = k * SLOT_BYTES;
						if ({slot_mem[base + 3], slot_mem[base + 2]} == rep_id)
							r.status = bds_pkg::STATUS_DUP;
					end
					if (r.status == bds_pkg::STATUS_STORED) begin
						slot_mem[stored_n * SLOT_BYTES + len + 1] = it.rssi;
						stored_n++;
					end
				end
				rep_pos = '0;
				rep_len = '0;
				rep_id = '0;
			end else begin
				if (rep_pos < bds_pkg::POS_LIMIT) rep_pos = rep_pos + 6'd1;
				r.status = bds_pkg::STATUS_TAKEN;
			end
		end
		r.entry_count = 5'(stored_n);
		return r;
	endfunction

	function automatic bds_pkg::item_t rand_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return bds_pkg::item_t'(raw[59:0]);
	endfunction

	task automatic push_noise();
		bds_pkg::item_t it;
		it = rand_item();
		it.cmd = bds_pkg::CMD_REPORT;
		if ($urandom_range(0, 1) == 0)
			it.peer_address_high = addr_pat ^ (32'h1 << $urandom_range(0, 31));
		byte_cmd_q.push_back(it);
	endtask

	task automatic push_report_byte(input logic [31:0] a, input logic [7:0] d,
			input logic l, input logic [7:0] r);
		bds_pkg::item_t it;
		it = rand_item();
		it.cmd = bds_pkg::CMD_REPORT;
		it.peer_address_high = a;
		it.data_byte = d;
		it.last_byte = l;
		it.rssi = r;
		byte_cmd_q.push_back(it);
		gen_count++;
	endtask

	task automatic push_read(input logic [1:0] c, input logic [3:0] e, input logic [4:0] o);
		bds_pkg::item_t it;
		it = rand_item();
		it.cmd = c;
		it.read_entry = e;
		it.read_offset = o;
		byte_cmd_q.push_back(it);
		gen_count++;
	endtask

	task automatic push_clear();
		bds_pkg::item_t it;
		it = rand_item();
		it.cmd = bds_pkg::CMD_CLEAR;
		byte_cmd_q.push_back(it);
		gen_count++;
	endtask

	// report with length byte, id bytes and random filler; ends with last unless abandoned
	task automatic add_report(input int nbytes, input logic [7:0] len, input logic [15:0] id,
			input bit closed);
		logic [7:0] d;
		int k;
		for (k = 0; k < nbytes; k++) begin
			if ($urandom_range(0, 99) < noise_pct) push_noise();
			d = 8'($urandom);
			if (k == 0) d = len;
			if (k == 2) d = id[7:0];
			if (k == 3) d = id[15:8];
			push_report_byte(addr_pat, d, closed && (k == nbytes - 1), 8'($urandom));
		end
	endtask

	task automatic gen_phase(input int n);
		int target;
		int pick;
		int len;
		int nbytes;
		logic [15:0] id;
		target = gen_count + n;
		while (gen_count < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					len = $urandom_range(0, SLOT_BYTES - 2);
					nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len + 3) : len + 1;
				end else if (pick < 96) begin
					len = $urandom_range(SLOT_BYTES - 1, 255);
					nbytes = $urandom_range(1, 6);
				end else begin
					len = $urandom_range(0, 255);
					nbytes = $urandom_range(60, 70);
				end
				add_report(nbytes, 8'(len), id, 1'b1);
			end else if (pick < 82) begin
				push_read($urandom_range(0, 1) ? bds_pkg::CMD_READ : bds_pkg::CMD_RSVD,
					4'($urandom), 5'($urandom));
			end else if (pick < 86) begin
				if ($urandom_range(0, 1) == 1)
					add_report($urandom_range(1, 8), 8'($urandom_range(0, 30)),
						16'($urandom), 1'b0);
				push_clear();
			end else begin
				push_noise();
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (byte_cmd_q.size() != 0 || in_valid || expected_status_q.size() != 0);
	endtask

	task automatic write_pattern(input logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		addr_pat = v;
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_status_q.push_back(dedup_predict(in_item));
			items_in++;
		end
		if (!in_valid || !in_stall) begin
			if (byte_cmd_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				in_item <= byte_cmd_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bds_pkg::result_t exp_r;
		if (out_valid && !out_stall) begin
			results_seen++;
			status_cnt[status]++;
			if (expected_status_q.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				errors++;
			end else begin
				exp_r = expected_status_q.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					errors++;
				end
				if (read_byte !== exp_r.read_byte) begin
					$error("read_byte: expected %0d, got %0d", exp_r.read_byte, read_byte);
					errors++;
				end
				if (entry_count !== exp_r.entry_count) begin
					$error("entry_count: expected %0d, got %0d", exp_r.entry_count,
						entry_count);
					errors++;
				end
			end
		end
		if (hold_served != hold_reqs) begin
			hold_served = hold_reqs;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reads, mismatches, short, long, duplicate and overlong reports
		push_read(bds_pkg::CMD_READ, 4'd0, 5'd0);
		push_read(bds_pkg::CMD_RSVD, 4'd15, 5'd31);
		push_report_byte(addr_pat ^ 32'h1, 8'h00, 1'b0, 8'h00);
		push_report_byte(32'h0, 8'hFF, 1'b1, 8'hFF);
		push_report_byte(addr_pat, 8'd0, 1'b1, 8'h80);
		add_report(4, 8'd3, 16'hFFFF, 1'b0);
		push_report_byte(addr_pat, 8'hFF, 1'b1, 8'h7F);
		push_report_byte(addr_pat, 8'd5, 1'b1, 8'h11);
		push_report_byte(addr_pat, 8'd255, 1'b1, 8'h22);
		push_report_byte(addr_pat, 8'd31, 1'b1, 8'h33);
		add_report(4, 8'd30, 16'h1234, 1'b1);
		add_report(5, 8'd1, 16'h5678, 1'b1);
		push_read(bds_pkg::CMD_READ, 4'd3, 5'd2);
		push_read(bds_pkg::CMD_READ, 4'd3, 5'd3);
		push_clear();
		push_read(bds_pkg::CMD_READ, 4'd0, 5'd1);
		wait_drained();

		noise_pct = 5;
		write_pattern(32'hFFFF_FFFF);
		@(negedge clk);
		hold_reqs++;
		gen_phase(PHASE_ITEMS);
		wait_drained();

		sender_idle_pct = 81;
		write_pattern(32'h0000_0000);
		gen_phase(PHASE_ITEMS);
		wait_drained();

		sender_idle_pct = 0;
		recv_stall_pct = 81;
		write_pattern($urandom);
		gen_phase(PHASE_ITEMS);
		wait_drained();

		sender_idle_pct = 10;
		recv_stall_pct = 10;
		write_pattern(bds_pkg::ADDR_PATTERN_RST);
		gen_phase(PHASE_ITEMS);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d items in, %0d results; stored %0d, dup %0d, full %0d, long %0d",
			items_in, results_seen, status_cnt[bds_pkg::STATUS_STORED],
			status_cnt[bds_pkg::STATUS_DUP], status_cnt[bds_pkg::STATUS_FULL],
			status_cnt[bds_pkg::STATUS_TOO_LONG]);
		$display("summary: %0d address mismatches, %0d clears, %0d reads over five patterns",
			status_cnt[bds_pkg::STATUS_MISMATCH], status_cnt[bds_pkg::STATUS_CLEARED],
			status_cnt[bds_pkg::STATUS_READ]);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bds_pkg.sv
rtl/bds_slot_ram.sv
rtl/bds_ctrl.sv
rtl/beacon_dedup_store.sv
tb/sv/beacon_dedup_store_tb.sv
